FILE: sv/rfd_pkg.sv
`timescale 1ns / 1ps

package rfd_pkg;

   // Width of the red accumulator and of the reference sum
   localparam int SUM_WIDTH   = 32;
   localparam int PROD_WIDTH  = SUM_WIDTH + 8;
   localparam int RATIO_BASE  = 100;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] RATIO_RESET = 8'd108;
   localparam logic [7:0] GAP_RESET   = 8'd7;
   localparam logic [7:0] CHAN_MAX    = 8'd255;

   typedef enum logic [2:0] {
      REG_TINT_BLUE   = 3'd0,
      REG_TINT_GREEN  = 3'd1,
      REG_TINT_RED    = 3'd2,
      REG_FLASH_RATIO = 3'd3,
      REG_RECOLOR_GAP = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] tint_blue;
      logic [7:0] tint_green;
      logic [7:0] tint_red;
      logic [7:0] flash_ratio_percent;
      logic [7:0] recolor_gap_frames;
   } cfg_type;

   // One pixel as queued between the front and the back
   typedef struct packed {
      logic [7:0]           out_blue;
      logic [7:0]           out_green;
      logic [7:0]           out_red;
      logic                 end_of_frame;
      logic [SUM_WIDTH-1:0] red_sum;
   } item_type;

   function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? CHAN_MAX : s[7:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [SUM_WIDTH-1:0] s);
      logic [SUM_WIDTH:0] hi;
      hi = {1'b0, s} >> 32;
      return (hi != '0) ? 32'hFFFF_FFFF : 32'(s);
   endfunction

endpackage

FILE: sv/rfd_if.sv
`timescale 1ns / 1ps

interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pix_blue;
   logic [7:0] pix_green;
   logic [7:0] pix_red;
   logic       end_of_frame;

   modport source(output valid, pix_blue, pix_green, pix_red, end_of_frame, input ready);
   modport sink(input valid, pix_blue, pix_green, pix_red, end_of_frame, output ready);
endinterface

interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_blue;
   logic [7:0]  out_green;
   logic [7:0]  out_red;
   logic        frame_done;
   logic        flash_seen;
   logic [31:0] frame_red_sum;
   logic [31:0] frame_index;
   logic        recolor_due;

   modport source(output valid, out_blue, out_green, out_red, frame_done, flash_seen,
                  frame_red_sum, frame_index, recolor_due, input ready);
   modport sink(input valid, out_blue, out_green, out_red, frame_done, flash_seen,
                frame_red_sum, frame_index, recolor_due, output ready);
endinterface

interface rfd_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/frame_red_flash_detector_top.sv
`timescale 1ns / 1ps

// Channel   Modport  Transfer when       Payload
// req_bus   sink     valid && ready      pix_blue, pix_green, pix_red, end_of_frame
// rsp_bus   source   valid && ready      tinted pixel, frame_done, flash_seen,
//                                        frame_red_sum, frame_index, recolor_due
// csr_bus   sink     valid (ready = 1)   index 0..4, data 8 bits
//
// One pixel per clock sustained while rsp_bus is ready; from req to rsp transfer
// a pixel passes tint and sum, queue, multiply, decide into the output register.
// The frame-end check runs on registered products, so frame ends may follow
// back to back. A four-entry queue between front and back absorbs rsp stalls.
// Reset is synchronous; configuration takes its documented defaults.

module frame_red_flash_detector_top (
   input  logic      clock,
   input  logic      reset,
   rfd_req_if.sink   req_bus,
   rfd_rsp_if.source rsp_bus,
   rfd_csr_if.sink   csr_bus
);
   import rfd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push, pop, queue_full, queue_empty;
   item_type push_item, head_item;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            REG_TINT_BLUE:   cfg_in.tint_blue           = csr_bus.data;
            REG_TINT_GREEN:  cfg_in.tint_green          = csr_bus.data;
            REG_TINT_RED:    cfg_in.tint_red            = csr_bus.data;
            REG_FLASH_RATIO: cfg_in.flash_ratio_percent = csr_bus.data;
            REG_RECOLOR_GAP: cfg_in.recolor_gap_frames  = csr_bus.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint_blue           <= '0;
         cfg_ff.tint_green          <= '0;
         cfg_ff.tint_red            <= '0;
         cfg_ff.flash_ratio_percent <= RATIO_RESET;
         cfg_ff.recolor_gap_frames  <= GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   rfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   rfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

FILE: sv/rfd_front.sv
`timescale 1ns / 1ps

module rfd_front (
   input  logic              clock,
   input  logic              reset,
   rfd_req_if.sink           req_bus,
   input  rfd_pkg::cfg_type  cfg,
   input  logic              queue_full,
   output logic              push,
   output rfd_pkg::item_type push_item
);
   import rfd_pkg::*;

   logic [SUM_WIDTH-1:0] acc_ff, acc_in;
   logic [SUM_WIDTH:0]   raw_sum;
   logic [SUM_WIDTH-1:0] sum;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // untinted red is summed, saturating at the top of the accumulator
   assign raw_sum = {1'b0, acc_ff} + {{SUM_WIDTH-7{1'b0}}, req_bus.pix_red};
   assign sum     = raw_sum[SUM_WIDTH] ? '1 : raw_sum[SUM_WIDTH-1:0];

   always_comb begin
      push_item.out_blue     = sat_add8(req_bus.pix_blue, cfg.tint_blue);
      push_item.out_green    = sat_add8(req_bus.pix_green, cfg.tint_green);
      push_item.out_red      = sat_add8(req_bus.pix_red, cfg.tint_red);
      push_item.end_of_frame = req_bus.end_of_frame;
      push_item.red_sum      = sum;
   end

   always_comb begin
      acc_in = acc_ff;
      if (push) begin
         acc_in = req_bus.end_of_frame ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_acc_clears: assert property (@(posedge clock) disable iff (reset)
      push && req_bus.end_of_frame |=> acc_ff == '0)
      else $error("accumulator not cleared after frame end");
   a_acc_grows: assert property (@(posedge clock) disable iff (reset)
      push && !req_bus.end_of_frame |=> acc_ff >= $past(acc_ff))
      else $error("accumulator went down inside a frame");
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      push |-> push_item.red_sum >= acc_ff)
      else $error("queued sum below accumulator");
`endif

endmodule

FILE: sv/rfd_queue.sv
`timescale 1ns / 1ps

module rfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rfd_pkg::item_type push_item,
   input  logic              pop,
   output rfd_pkg::item_type head_item,
   output logic              full,
   output logic              empty
);
   import rfd_pkg::*;

   item_type                store_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      !full |-> QPTR_WIDTH'(wr_ptr_ff - rd_ptr_ff) == QPTR_WIDTH'(count_ff))
      else $error("queue count out of step with pointers");
`endif

endmodule

FILE: sv/rfd_back.sv
`timescale 1ns / 1ps

module rfd_back (
   input  logic              clock,
   input  logic              reset,
   input  rfd_pkg::cfg_type  cfg,
   input  logic              queue_empty,
   input  rfd_pkg::item_type head_item,
   output logic              pop,
   rfd_rsp_if.source         rsp_bus
);
   import rfd_pkg::*;

   // multiply stage
   logic                  mul_valid_ff, mul_valid_in;
   item_type              mul_item_ff;
   logic [PROD_WIDTH-1:0] sum_base_ff;     // sum * 100
   logic [PROD_WIDTH-1:0] sum_ratio_ff;    // sum * ratio

   // frame state
   logic [SUM_WIDTH-1:0]  reference_ff, reference_in;
   logic [PROD_WIDTH-1:0] ref_scaled_ff, ref_scaled_in;
   logic [31:0]           frame_cnt_ff, frame_cnt_in;
   logic [31:0]           last_recolor_ff, last_recolor_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_blue_ff, out_green_ff, out_red_ff;
   logic                  frame_done_ff, flash_seen_ff, recolor_due_ff;
   logic [31:0]           frame_sum_ff, frame_index_ff;

   logic                  out_free, mul_free, decide;
   logic                  flash, due, gap_ok;
   logic [31:0]           frame_num, frame_gap;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign decide   = mul_valid_ff && out_free;
   assign mul_free = !mul_valid_ff || decide;
   assign pop      = !queue_empty && mul_free;

   always_comb begin
      mul_valid_in = mul_free ? pop : mul_valid_ff;
      out_valid_in = out_free ? mul_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mul_item_ff  <= head_item;
         sum_base_ff  <= PROD_WIDTH'(head_item.red_sum) * PROD_WIDTH'(RATIO_BASE);
         sum_ratio_ff <= PROD_WIDTH'(head_item.red_sum) * PROD_WIDTH'(cfg.flash_ratio_percent);
      end
   end

   // flash and recolor decision on the registered products
   always_comb begin
      frame_num = frame_cnt_ff + 32'd1;
      frame_gap = frame_num - last_recolor_ff;
      flash     = (reference_ff != '0) && (sum_base_ff > ref_scaled_ff);
      gap_ok    = (last_recolor_ff == '0) || (frame_gap > 32'(cfg.recolor_gap_frames));
      due       = flash && gap_ok;
   end

   always_comb begin
      reference_in    = reference_ff;
      frame_cnt_in    = frame_cnt_ff;
      last_recolor_in = last_recolor_ff;
      // kept in step with the reference and the ratio register
      ref_scaled_in   = PROD_WIDTH'(reference_ff) * PROD_WIDTH'(cfg.flash_ratio_percent);
      if (decide && mul_item_ff.end_of_frame) begin
         frame_cnt_in = frame_num;
         if (due) begin
            last_recolor_in = frame_num;
         end
         if (!flash) begin
            reference_in  = mul_item_ff.red_sum;
            ref_scaled_in = sum_ratio_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
         reference_ff    <= '0;
         ref_scaled_ff   <= '0;
         frame_cnt_ff    <= '0;
         last_recolor_ff <= '0;
      end else begin
         mul_valid_ff    <= mul_valid_in;
         out_valid_ff    <= out_valid_in;
         reference_ff    <= reference_in;
         ref_scaled_ff   <= ref_scaled_in;
         frame_cnt_ff    <= frame_cnt_in;
         last_recolor_ff <= last_recolor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decide) begin
         out_blue_ff    <= mul_item_ff.out_blue;
         out_green_ff   <= mul_item_ff.out_green;
         out_red_ff     <= mul_item_ff.out_red;
         frame_done_ff  <= mul_item_ff.end_of_frame;
         flash_seen_ff  <= mul_item_ff.end_of_frame && flash;
         recolor_due_ff <= mul_item_ff.end_of_frame && due;
         frame_sum_ff   <= mul_item_ff.end_of_frame ? sat32(mul_item_ff.red_sum) : 32'd0;
         frame_index_ff <= mul_item_ff.end_of_frame ? frame_cnt_ff : 32'd0;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.out_blue      = out_blue_ff;
   assign rsp_bus.out_green     = out_green_ff;
   assign rsp_bus.out_red       = out_red_ff;
   assign rsp_bus.frame_done    = frame_done_ff;
   assign rsp_bus.flash_seen    = flash_seen_ff;
   assign rsp_bus.frame_red_sum = frame_sum_ff;
   assign rsp_bus.frame_index   = frame_index_ff;
   assign rsp_bus.recolor_due   = recolor_due_ff;

`ifndef NO_ASSERTIONS
   a_mid_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !frame_done_ff |->
         !flash_seen_ff && !recolor_due_ff && frame_sum_ff == '0 && frame_index_ff == '0)
      else $error("frame fields set on a pixel inside a frame");
   a_due_needs_flash: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && recolor_due_ff |-> flash_seen_ff)
      else $error("recolor request without flash");
   a_ref_takes_sum: assert property (@(posedge clock) disable iff (reset)
      decide && mul_item_ff.end_of_frame && !flash |=>
         reference_ff == $past(mul_item_ff.red_sum))
      else $error("reference not updated on a quiet frame");
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      decide && mul_item_ff.end_of_frame |=> frame_cnt_ff == $past(frame_cnt_ff) + 32'd1)
      else $error("frame counter missed a frame end");
`endif

endmodule
